// File: rtl/rdda_pkg.sv
package rdda_pkg;

  localparam int MaxLen     = 256;
  localparam int IdxW       = $clog2(MaxLen);
  localparam int LenW       = IdxW + 1;
  localparam int CellW      = 2 * IdxW;
  localparam int Cells      = MaxLen * MaxLen;
  localparam int WalkBudget = 2 * MaxLen;
  localparam int StepW      = $clog2(WalkBudget) + 1;
  localparam int DistW      = 8;
  localparam int WeightW    = 17;
  localparam int ProdW      = DistW + WeightW;
  localparam int AccW       = 48;

  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};
  localparam logic [AccW-1:0]  AccMax  = {AccW{1'b1}};
  localparam logic [LenW-1:0]  SeqLenReset = LenW'(MaxLen);

  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_COMPUTE = 2'd1,
    MODE_READ    = 2'd2,
    MODE_CLEAR   = 2'd3
  } mode_e;

  typedef enum logic {
    REG_SEQ_LENGTH = 1'b0,
    REG_NONE       = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic [LenW-1:0]    position;
    logic [LenW-1:0]    partner;
    logic [WeightW-1:0] weight;
    logic [LenW-1:0]    row;
    logic [LenW-1:0]    col;
  } in_item_t;

  typedef struct packed {
    logic [AccW-1:0] accumulated_value;
    logic            status;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic walk_step;
    logic add_prev;
    logic sat_d;
    logic wr_sample;
    logic acc_upd;
    logic clr_step;
    logic rd_out;
  } dp_cmd_t;

  typedef struct packed {
    logic k_gt_i;
    logic budget_out;
    logic p_zero;
    logic prev_need;
    logic last_j;
    logic last_i;
    logic len_short;
    logic clr_last;
    logic out_valid;
  } dp_status_t;

  function automatic logic [DistW-1:0] sat_dist(logic [DistW-1:0] a, logic [DistW:0] b);
    logic [DistW+1:0] s;
    s = {2'b00, a} + {1'b0, b};
    return (s > {2'b00, DistMax}) ? DistMax : s[DistW-1:0];
  endfunction

endpackage

// File: rtl/rdda_ram.sv
module rdda_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/rdda_ctrl.sv
module rdda_ctrl import rdda_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] mode_i,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output logic       in_ready_o,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CLR, ST_RD, ST_STEP, ST_PDEC, ST_SADD, ST_WR, ST_ACC
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE) && (!status_i.out_valid || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.accept = accept;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (mode_i)
            MODE_COMPUTE: if (!status_i.len_short) state_d = ST_STEP;
            MODE_READ:    state_d = ST_RD;
            MODE_CLEAR:   state_d = ST_CLR;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      ST_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_RD: begin
        cmd_o.rd_out = 1'b1;
        state_d = ST_IDLE;
      end
      ST_STEP: begin
        if (!status_i.k_gt_i) begin
          state_d = ST_WR;
        end else if (status_i.budget_out) begin
          cmd_o.sat_d = 1'b1;
          state_d = ST_WR;
        end else begin
          state_d = ST_PDEC;
        end
      end
      ST_PDEC: begin
        cmd_o.walk_step = 1'b1;
        if (status_i.p_zero) begin
          state_d = status_i.prev_need ? ST_SADD : ST_WR;
        end else begin
          state_d = ST_STEP;
        end
      end
      ST_SADD: begin
        cmd_o.add_prev = 1'b1;
        state_d = ST_WR;
      end
      ST_WR: begin
        cmd_o.wr_sample = 1'b1;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc_upd = 1'b1;
        state_d = (status_i.last_j && status_i.last_i) ? ST_IDLE : ST_STEP;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/rdda_dp.sv
module rdda_dp import rdda_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [LenW-1:0] len_i,
  input  in_item_t        in_data_i,
  input  logic            out_ready_i,
  input  dp_cmd_t         cmd_i,
  output dp_status_t      status_o,
  output logic            out_valid_o,
  output out_item_t       out_data_o
);

  logic [LenW-1:0]    i_q, j_q, k_q;
  logic [DistW-1:0]   d_q;
  logic [StepW-1:0]   steps_q;
  logic [WeightW-1:0] weight_q;
  logic [ProdW-1:0]   prod_q;
  logic [CellW-1:0]   clr_q;
  logic               rd_bad_q;
  logic               out_valid_q;
  out_item_t          out_data_q;

  logic [LenW-1:0]  p_rd;
  logic [DistW-1:0] s_rd;
  logic [AccW-1:0]  acc_rd;
  logic [LenW-1:0]  km1;
  logic [CellW-1:0] cell_ij, cell_prev, rd_cell, acc_raddr, acc_waddr;
  logic [AccW:0]    acc_sum;
  logic [AccW-1:0]  acc_sat, acc_wdata;
  logic             acc_we, p_we, pos_ok, rd_ok;
  logic [LenW:0]    i_plus2;
  logic [LenW-1:0]  j_next;

  assign km1       = k_q - LenW'(1);
  assign cell_ij   = {i_q[IdxW-1:0] - IdxW'(1), j_q[IdxW-1:0] - IdxW'(1)};
  assign cell_prev = {i_q[IdxW-1:0] - IdxW'(1), km1[IdxW-1:0] - IdxW'(1)};
  assign rd_cell   = {in_data_i.row[IdxW-1:0] - IdxW'(1), in_data_i.col[IdxW-1:0] - IdxW'(1)};
  assign i_plus2   = {1'b0, i_q} + (LenW+1)'(2);
  assign j_next    = j_q + LenW'(1);

  assign pos_ok = (in_data_i.position != '0) && (in_data_i.position <= LenW'(MaxLen));
  assign rd_ok  = (in_data_i.row != '0) && (in_data_i.col <= len_i)
                  && (in_data_i.row < in_data_i.col);
  assign p_we   = cmd_i.accept && (in_data_i.mode == MODE_LOAD) && pos_ok;

  rdda_ram #(.Width(LenW), .Depth(MaxLen)) u_partner (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (in_data_i.position[IdxW-1:0] - IdxW'(1)),
    .wdata_i (in_data_i.partner),
    .raddr_i (km1[IdxW-1:0]),
    .rdata_o (p_rd)
  );

  rdda_ram #(.Width(DistW), .Depth(Cells)) u_sample (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_sample),
    .waddr_i (cell_ij),
    .wdata_i (d_q),
    .raddr_i (cell_prev),
    .rdata_o (s_rd)
  );

  assign acc_raddr = (cmd_i.accept && (in_data_i.mode == MODE_READ)) ? rd_cell : cell_ij;
  assign acc_sum   = {1'b0, acc_rd} + (AccW+1)'(prod_q);
  assign acc_sat   = acc_sum[AccW] ? AccMax : acc_sum[AccW-1:0];
  assign acc_we    = cmd_i.clr_step || cmd_i.acc_upd;
  assign acc_waddr = cmd_i.clr_step ? clr_q : cell_ij;
  assign acc_wdata = cmd_i.clr_step ? '0 : acc_sat;

  rdda_ram #(.Width(AccW), .Depth(Cells)) u_acc (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rd)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      weight_q <= in_data_i.weight;
      rd_bad_q <= !rd_ok;
      if (in_data_i.mode == MODE_COMPUTE) begin
        i_q     <= LenW'(1);
        j_q     <= LenW'(2);
        k_q     <= LenW'(2);
        d_q     <= '0;
        steps_q <= '0;
      end
    end
    if (cmd_i.walk_step) begin
      steps_q <= steps_q + StepW'(1);
      if (p_rd == '0) begin
        if (!(km1 > i_q)) d_q <= sat_dist(d_q, (DistW+1)'(1));
      end else if ((p_rd < j_q) && (p_rd >= i_q)) begin
        if (p_rd > i_q) begin
          k_q <= p_rd - LenW'(1);
          d_q <= sat_dist(d_q, (DistW+1)'(2));
        end else begin
          k_q <= p_rd;
          d_q <= sat_dist(d_q, (DistW+1)'(1));
        end
      end else begin
        k_q <= km1;
        d_q <= sat_dist(d_q, (DistW+1)'(1));
      end
    end
    if (cmd_i.add_prev) d_q <= sat_dist(d_q, {1'b0, s_rd} + (DistW+1)'(1));
    if (cmd_i.sat_d) d_q <= DistMax;
    if (cmd_i.wr_sample) prod_q <= ProdW'(d_q) * ProdW'(weight_q);
    if (cmd_i.acc_upd) begin
      d_q     <= '0;
      steps_q <= '0;
      if (j_q != len_i) begin
        j_q <= j_next;
        k_q <= j_next;
      end else begin
        i_q <= i_q + LenW'(1);
        j_q <= i_plus2[LenW-1:0];
        k_q <= i_plus2[LenW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + CellW'(1);
      end else if (cmd_i.accept) begin
        clr_q <= '0;
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.accept && (in_data_i.mode != MODE_READ)) begin
        out_valid_q <= 1'b1;
        out_data_q.accumulated_value <= '0;
        out_data_q.status <= (in_data_i.mode == MODE_LOAD) && !pos_ok;
      end
      if (cmd_i.rd_out) begin
        out_valid_q <= 1'b1;
        out_data_q.accumulated_value <= rd_bad_q ? '0 : acc_rd;
        out_data_q.status <= rd_bad_q;
      end
    end
  end

  assign status_o.k_gt_i     = k_q > i_q;
  assign status_o.budget_out = steps_q >= StepW'(WalkBudget);
  assign status_o.p_zero     = p_rd == '0;
  assign status_o.prev_need  = km1 > i_q;
  assign status_o.last_j     = j_q == len_i;
  assign status_o.last_i     = i_plus2 > {1'b0, len_i};
  assign status_o.len_short  = len_i < LenW'(2);
  assign status_o.clr_last   = clr_q == {CellW{1'b1}};
  assign status_o.out_valid  = out_valid_q;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: rtl/rna_directed_distance_accumulator_core.sv
// Directed path distance accumulator. Load, read and clear items take one beat; a read
// answers from the registered accumulator read port in ST_RD. After reset, and after each
// clear item, a clearing pass writes zero to all 65536 accumulator entries, one per cycle,
// during which no beat is accepted. A compute item walks every pair i<j of the sequence
// length; each walk step passes through ST_STEP and ST_PDEC (the partner memory read port
// is registered), and after the walk ST_WR and ST_ACC do the sample and accumulator updates
// for the pair.
module rna_directed_distance_accumulator_core import rdda_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o
);

  logic [LenW-1:0] seq_len_q;
  logic [LenW-1:0] len;
  logic            reg_hit;
  dp_cmd_t         cmd;
  dp_status_t      status;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_SEQ_LENGTH) && (paddr[1:0] == 2'b00);
  assign prdata  = reg_hit ? 32'(seq_len_q) : '0;
  assign len     = (seq_len_q > LenW'(MaxLen)) ? LenW'(MaxLen) : seq_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_len_q <= SeqLenReset;
    end else if (psel && penable && pwrite && reg_hit) begin
      seq_len_q <= pwdata[LenW-1:0];
    end
  end

  rdda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .mode_i      (in_data_i.mode),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .in_ready_o  (in_ready_o),
    .cmd_o       (cmd)
  );

  rdda_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .len_i       (len),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// File: tb/tb_rna_directed_distance_accumulator_core.sv
module tb_rna_directed_distance_accumulator_core;
  import rdda_pkg::*;

  localparam int unsigned IdleLimit = 4000000;
  localparam int unsigned TailWait  = 64;

  typedef struct {
    logic [1:0]         mode;
    logic [LenW-1:0]    position;
    logic [LenW-1:0]    partner;
    logic [WeightW-1:0] weight;
    logic [LenW-1:0]    row;
    logic [LenW-1:0]    col;
    bit                 fixed;
    logic [AccW-1:0]    fixed_value;
    logic               fixed_status;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_ready_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_item_t   out_data_o;

  rna_directed_distance_accumulator_core dut (.*);

  // predictor state
  logic [LenW-1:0] pair_of[MaxLen];
  logic [DistW-1:0] last_dist[Cells];
  logic [AccW-1:0] acc_sum[Cells];
  int unsigned     fold_len;

  out_item_t   pending_results[$];
  bit          use_fixed;
  out_item_t   fixed_result;
  int unsigned mismatches;
  int unsigned idle_cycles;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned computes_sent;
  int unsigned burst_left;
  bit          stim_done;
  int unsigned fold[MaxLen+1];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned walk_dist(int unsigned i, int unsigned j);
    int unsigned d, k, steps, p, prev;
    d = 0;
    k = j;
    steps = 0;
    while (k > i) begin
      if (steps >= WalkBudget) return DistMax;
      steps++;
      p = pair_of[k-1];
      if (p == 0) begin
        prev = (k - 1 > i) ? last_dist[(i-1)*MaxLen + k-2] : 0;
        d += prev + 1;
        break;
      end else if (p < j && p >= i) begin
        k = p;
        d++;
        if (k > i) begin
          k--;
          d++;
        end
      end else begin
        k--;
        d++;
      end
    end
    return (d > DistMax) ? DistMax : d;
  endfunction

  function automatic out_item_t predict_entry(in_item_t it);
    out_item_t   r;
    int unsigned len, d, c;
    logic [63:0] sum;
    r = '0;
    len = (fold_len > MaxLen) ? MaxLen : fold_len;
    case (mode_e'(it.mode))
      MODE_LOAD: begin
        if (it.position >= 1 && it.position <= MaxLen) pair_of[it.position-1] = it.partner;
        else r.status = 1'b1;
      end
      MODE_COMPUTE: begin
        for (int unsigned i = 1; i <= len; i++) begin
          for (int unsigned j = i + 1; j <= len; j++) begin
            d = walk_dist(i, j);
            c = (i-1)*MaxLen + j-1;
            last_dist[c] = d[DistW-1:0];
            sum = 64'(acc_sum[c]) + 64'(d) * 64'(it.weight);
            acc_sum[c] = (sum > 64'(AccMax)) ? AccMax : sum[AccW-1:0];
          end
        end
      end
      MODE_READ: begin
        if (it.row >= 1 && it.col <= len && it.row < it.col)
          r.accumulated_value = acc_sum[(it.row-1)*MaxLen + it.col-1];
        else r.status = 1'b1;
      end
      default: begin
        foreach (acc_sum[n]) acc_sum[n] = '0;
      end
    endcase
    return r;
  endfunction

  // scoreboard and watchdog
  always @(posedge clk_i) begin
    out_item_t want, got;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        want = predict_entry(in_data_i);
        if (use_fixed) want = fixed_result;
        pending_results.push_back(want);
      end
      if (out_valid_o && out_ready_i) begin
        got = out_data_o;
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result value=%0h status=%0b",
                                         got.accumulated_value, got.status);
        end else begin
          want = pending_results.pop_front();
          if (got.accumulated_value !== want.accumulated_value ||
              got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: exp value=%0h status=%0b got value=%0h status=%0b",
                       want.accumulated_value, want.status,
                       got.accumulated_value, got.status);
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog expired, %0d results outstanding", pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // receiver stall pattern
  initial begin
    int unsigned span;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      span = $urandom_range(1, 40);
      case ($urandom_range(0, 2))
        0: repeat (span) begin
          @(negedge clk_i);
          out_ready_i = 1'b1;
        end
        1: repeat (span) begin
          @(negedge clk_i);
          out_ready_i = ($urandom_range(0, 3) != 0);
        end
        default: repeat ($urandom_range(1, 6)) begin
          @(negedge clk_i);
          out_ready_i = 1'b0;
        end
      endcase
    end
  end

  task automatic send_beat(stim_row_t s);
    in_item_t it;
    if (burst_left == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    it.mode     = s.mode;
    it.position = s.position;
    it.partner  = s.partner;
    it.weight   = s.weight;
    it.row      = s.row;
    it.col      = s.col;
    use_fixed    = s.fixed;
    fixed_result = '{accumulated_value: s.fixed_value, status: s.fixed_status};
    in_valid_i = 1'b1;
    in_data_i  = it;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    items_sent++;
    if (mode_e'(s.mode) == MODE_COMPUTE) computes_sent++;
  endtask

  function automatic stim_row_t noise_row(mode_e m);
    stim_row_t s;
    s.mode     = m;
    s.position = LenW'($urandom());
    s.partner  = LenW'($urandom());
    s.weight   = WeightW'($urandom());
    s.row      = LenW'($urandom());
    s.col      = LenW'($urandom());
    s.fixed    = 1'b0;
    s.fixed_value  = '0;
    s.fixed_status = 1'b0;
    return s;
  endfunction

  task automatic send_load(int unsigned pos, int unsigned prt);
    stim_row_t s;
    s = noise_row(MODE_LOAD);
    s.position = LenW'(pos);
    s.partner  = LenW'(prt);
    send_beat(s);
  endtask

  task automatic drain_and_set_len(int unsigned len);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0 || !in_ready_o) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = 3'(4 * REG_SEQ_LENGTH);
    pwdata = len;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    fold_len = len;
    @(negedge clk_i);
  endtask

  // nested fold over 1..len, with a crossing pair or a partner past the end now and then
  task automatic build_fold(int unsigned len);
    int unsigned a, b;
    bit ok;
    for (int unsigned n = 1; n <= len; n++) fold[n] = 0;
    repeat ($urandom_range(0, len)) begin
      a = $urandom_range(1, len);
      b = $urandom_range(1, len);
      if (a > b) begin
        int unsigned t;
        t = a; a = b; b = t;
      end
      ok = (b > a + 1) && fold[a] == 0 && fold[b] == 0;
      for (int unsigned n = a + 1; n < b && ok; n++)
        if (fold[n] != 0 && (fold[n] < a || fold[n] > b)) ok = 0;
      if (ok || (b > a && fold[a] == 0 && fold[b] == 0 && $urandom_range(0, 9) == 0)) begin
        fold[a] = b;
        fold[b] = a;
      end
    end
    if ($urandom_range(0, 7) == 0) fold[$urandom_range(1, len)] = $urandom_range(len + 1, 511);
    for (int unsigned n = 1; n <= len; n++) send_load(n, fold[n]);
  endtask

  stim_row_t directed[$];

  initial begin
    stim_row_t   s;
    int unsigned len, r;
    int unsigned lengths[5] = '{1, 3, 9, 20, 32};
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    fold_len = 256;
    use_fixed = 1'b0;
    fixed_result = '0;
    mismatches = 0; idle_cycles = 0; items_sent = 0; results_seen = 0;
    computes_sent = 0; burst_left = 0; stim_done = 0;
    foreach (pair_of[n]) pair_of[n] = '0;
    foreach (last_dist[n]) last_dist[n] = '0;
    foreach (acc_sum[n]) acc_sum[n] = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // every position gets a defined partner before any compute
    for (int unsigned n = 1; n <= MaxLen; n++) send_load(n, 0);

    //                 mode          pos  prt   weight   row  col  fixed value  st
    directed = '{
      '{MODE_READ,     0,   0,   0,       1,   2,   1,    48'd0, 1'b0},
      '{MODE_READ,     0,   0,   0,       1,   256, 1,    48'd0, 1'b0},
      '{MODE_READ,     0,   0,   0,       0,   5,   1,    48'd0, 1'b1},
      '{MODE_READ,     0,   0,   0,       5,   5,   1,    48'd0, 1'b1},
      '{MODE_READ,     0,   0,   0,       3,   2,   1,    48'd0, 1'b1},
      '{MODE_READ,     0,   0,   0,       1,   257, 1,    48'd0, 1'b1},
      '{MODE_READ,     0,   0,   0,       511, 511, 1,    48'd0, 1'b1},
      '{MODE_LOAD,     0,   5,   0,       0,   0,   1,    48'd0, 1'b1},
      '{MODE_LOAD,     257, 5,   0,       0,   0,   1,    48'd0, 1'b1},
      '{MODE_LOAD,     511, 511, 131071,  511, 511, 1,    48'd0, 1'b1},
      '{MODE_LOAD,     256, 511, 0,       0,   0,   1,    48'd0, 1'b0},
      '{MODE_COMPUTE,  0,   0,   131071,  0,   0,   1,    48'd0, 1'b0},
      '{MODE_READ,     0,   0,   0,       1,   2,   0,    48'd0, 1'b0},
      '{MODE_READ,     0,   0,   0,       1,   256, 0,    48'd0, 1'b0},
      '{MODE_READ,     0,   0,   0,       255, 256, 0,    48'd0, 1'b0},
      '{MODE_READ,     0,   0,   0,       100, 200, 0,    48'd0, 1'b0},
      '{MODE_CLEAR,    0,   0,   0,       0,   0,   1,    48'd0, 1'b0},
      '{MODE_READ,     0,   0,   0,       1,   256, 1,    48'd0, 1'b0},
      '{MODE_LOAD,     256, 0,   0,       0,   0,   1,    48'd0, 1'b0}
    };
    foreach (directed[n]) send_beat(directed[n]);

    foreach (lengths[p]) begin
      len = lengths[p];
      drain_and_set_len(len);
      build_fold(len);
      repeat (50) begin
        r = $urandom_range(0, 99);
        if (r < 6) build_fold(len);
        else if (r < 18) send_beat(noise_row(MODE_COMPUTE));
        else if (r < 75 && len > 1) begin
          s = noise_row(MODE_READ);
          s.row = $urandom_range(1, len - 1);
          s.col = $urandom_range(s.row + 1, len);
          send_beat(s);
        end else if (r < 88) send_beat(noise_row(MODE_READ));
        else if (r < 92 && len > 1) send_load($urandom_range(2, len), $urandom_range(0, 511));
        else if (r == 99 && p == 2) send_beat(noise_row(MODE_CLEAR));
        else begin
          s = noise_row(MODE_LOAD);
          s.position = $urandom_range(257, 511);
          send_beat(s);
        end
      end
    end

    // full length once more with the fully unpaired table
    drain_and_set_len(256);
    for (int unsigned n = 1; n <= MaxLen; n++) send_load(n, 0);
    send_beat(noise_row(MODE_COMPUTE));
    repeat (40) begin
      s = noise_row(MODE_READ);
      s.row = $urandom_range(1, 255);
      s.col = $urandom_range(s.row + 1, 256);
      send_beat(s);
    end
    in_valid_i = 1'b0;
    stim_done = 1;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TailWait) @(posedge clk_i);
    $display("%0d items sent (%0d computes), %0d results checked, lengths 1 to 256",
             items_sent, computes_sent, results_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
